// ===== design/bsa_pkg.sv =====
// bsa_pkg: shared types, codes and the byte-order mapping of the bitmap slot allocator.
// Used by bsa_word_unit, bitmap_slot_allocator and its testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

   // Request function codes
   localparam logic [1:0] FN_ALLOC = 2'd0;
   localparam logic [1:0] FN_FREE  = 2'd1;
   localparam logic [1:0] FN_WRITE = 2'd2;
   localparam logic [1:0] FN_READ  = 2'd3;

   // Response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NOSPACE = 2'd1;
   localparam logic [1:0] STAT_RANGE   = 2'd2;
   localparam logic [1:0] STAT_NOTSET  = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SWAP  = 2'd0;
   localparam logic [1:0] CSR_C16   = 2'd1;
   localparam logic [1:0] CSR_TOTAL = 2'd2;

   localparam logic [13:0] TOTAL_RESET = 14'd8192;

   // Byte-order settings seen by the word unit
   typedef struct packed {
      logic swap;
      logic c16;
   } cfg_type;

   // What the word unit reports about one stored word
   typedef struct packed {
      logic        full;      // every logical bit set
      logic [4:0]  zero_pos;  // lowest clear logical bit
      logic        bit_set;   // selected bit currently set
      logic [31:0] new_raw;   // stored word with the selected bit toggled
   } unit_res_type;

   // Raw <-> logical mapping; it is its own inverse
   function automatic logic [31:0] bsa_convert(input logic [31:0] v, input cfg_type cfg);
      logic [31:0] r;
      if (!cfg.swap) begin
         r = v;
      end else if (cfg.c16) begin
         r = {v[23:16], v[31:24], v[7:0], v[15:8]};
      end else begin
         r = {v[7:0], v[15:8], v[23:16], v[31:24]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/bsa_word_unit.sv =====
// bsa_word_unit: the shared word unit - byte-order mapping, lowest-clear-bit search
// and single-bit toggle on one stored word. Depends on bsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsa_word_unit
   import bsa_pkg::*;
(
   input  wire logic [31:0]  raw_word,
   input  wire cfg_type      cfg,
   input  wire logic         pick_ffz,  // 1: act on lowest clear bit, 0: on bit_idx
   input  wire logic [4:0]   bit_idx,
   output unit_res_type      res
);

   logic [31:0] logical;
   logic [31:0] inv;
   logic [15:0] v16;
   logic [7:0]  v8;
   logic [3:0]  v4;
   logic [1:0]  v2;
   logic [4:0]  zpos;
   logic [4:0]  sel;
   logic [31:0] flip_mask;

   assign logical = bsa_convert(raw_word, cfg);
   assign inv     = ~logical;

   // Lowest clear bit by halving the window five times
   assign zpos[4] = (inv[15:0] == 16'd0);
   assign v16     = zpos[4] ? inv[31:16] : inv[15:0];
   assign zpos[3] = (v16[7:0] == 8'd0);
   assign v8      = zpos[3] ? v16[15:8] : v16[7:0];
   assign zpos[2] = (v8[3:0] == 4'd0);
   assign v4      = zpos[2] ? v8[7:4] : v8[3:0];
   assign zpos[1] = (v4[1:0] == 2'd0);
   assign v2      = zpos[1] ? v4[3:2] : v4[1:0];
   assign zpos[0] = ~v2[0];

   // Toggle the chosen logical bit and map back to stored order
   assign sel       = pick_ffz ? zpos : bit_idx;
   assign flip_mask = 32'd1 << sel;

   assign res.full     = (inv == 32'd0);
   assign res.zero_pos = zpos;
   assign res.bit_set  = logical[sel];
   assign res.new_raw  = bsa_convert(logical ^ flip_mask, cfg);

endmodule

`default_nettype wire

// ===== design/bitmap_slot_allocator.sv =====
// Bitmap slot allocator: allocate / free / raw access over a WORDS x 32 bitmap store.
// Holds the store, the sequencer and the config registers; uses bsa_pkg and bsa_word_unit.
//
// Usage:
//  - req_* : one request per transfer (func, slot_index, word_addr, word_in).
//  - rsp_* : exactly one response per request (status, granted_index, word_out).
//  - csr_* : register writes (index 0 swap_bytes, 1 chunk_16bit, 2 total_bits),
//    always ready; write only while no request is in flight.
//  - From request transfer to rsp_valid the sequencer passes ISSUE (store read),
//    EVAL (word unit), FIN and the response register; allocate stays in EVAL for
//    each of the n words examined (1 .. WORDS). The scan reads one stored word per
//    cycle through the single memory read port and the shared word unit.
//  - One request at a time; req_ready is high only while the sequencer is idle. A new
//    request may be taken while the previous response still waits.
//  - Reset: control and configuration registers take their reset values, then a
//    clearing pass writes zero to every word, with req_ready low.
//  - If the receiver stalls, the finished result waits in the sequencer until the
//    response register frees, and the response is held stable.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_slot_allocator
   import bsa_pkg::*;
#(
   parameter int WORDS = 256
)(
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_func,
   input  wire logic [12:0]  req_slot_index,
   input  wire logic [7:0]   req_word_addr,
   input  wire logic [31:0]  req_word_in,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [12:0]       rsp_granted_index,
   output logic [31:0]       rsp_word_out,
   // configuration port
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [13:0]  csr_wdata
);

   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int XW = (AW > 8) ? AW : 8;
   localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
   localparam logic [21:0]   CAP       = 22'(WORDS * 32);
   localparam logic [17:0]   WORDS_W   = 18'(WORDS);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ISSUE = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  cur_ff, cur_in;
   logic [1:0]     func_ff, func_in;
   logic [12:0]    slot_ff, slot_in;
   logic [7:0]     addr_ff, addr_in;
   logic [31:0]    win_ff, win_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [12:0]    res_granted_ff, res_granted_in;
   logic [31:0]    res_word_ff, res_word_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff;
   logic [12:0]    rsp_granted_ff;
   logic [31:0]    rsp_word_ff;
   logic           rsp_load;
   logic           swap_ff, c16_ff;
   logic [13:0]    total_ff;

   // store and its ports
   logic [31:0]    mem [WORDS];
   logic [31:0]    rd_data_ff;
   logic           rd_en, wr_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [31:0]    wr_data;

   cfg_type        cfg;
   unit_res_type   unit_res;
   logic [13:0]    lim;
   logic [21:0]    pos_w;
   logic           last_word;
   logic           addr_oor;
   logic           slot_oor;
   logic [AW-1:0]  cur_next;
   logic [XW-1:0]  slot_word_x;
   logic [XW-1:0]  addr_word_x;

   // effective allocation bound: smaller of total_bits and capacity
   assign lim = ({8'd0, total_ff} < CAP) ? total_ff : CAP[13:0];

   assign cfg.swap = swap_ff;
   assign cfg.c16  = c16_ff;

   bsa_word_unit u_unit (
      .raw_word (rd_data_ff),
      .cfg      (cfg),
      .pick_ffz (func_ff == FN_ALLOC),
      .bit_idx  (slot_ff[4:0]),
      .res      (unit_res)
   );

   assign pos_w       = 22'({cur_ff, unit_res.zero_pos});
   assign last_word   = (cur_ff == LAST_WORD);
   assign cur_next    = cur_ff + AW'(1);
   assign addr_oor    = ({10'd0, addr_ff} >= WORDS_W);
   assign slot_oor    = ({1'b0, slot_ff} >= lim);
   assign slot_word_x = XW'(req_slot_index[12:5]);
   assign addr_word_x = XW'(req_word_addr);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      func_in        = func_ff;
      slot_in        = slot_ff;
      addr_in        = addr_ff;
      win_in         = win_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_word_in    = res_word_ff;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = 32'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (last_word) begin
               cur_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cur_in = cur_next;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               slot_in  = req_slot_index;
               addr_in  = req_word_addr;
               win_in   = req_word_in;
               state_in = ST_ISSUE;
               unique case (req_func)
                  FN_ALLOC: cur_in = '0;
                  FN_FREE:  cur_in = slot_word_x[AW-1:0];
                  default:  cur_in = addr_word_x[AW-1:0];
               endcase
            end
         end

         ST_ISSUE: begin
            rd_en    = 1'b1;
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            res_granted_in = 13'd0;
            res_word_in    = 32'd0;
            res_status_in  = STAT_OK;
            state_in       = ST_FIN;
            unique case (func_ff)
               FN_ALLOC: begin
                  if (unit_res.full) begin
                     res_status_in = STAT_NOSPACE;
                     if (!last_word) begin
                        // full word: fetch the next one and stay here
                        rd_en    = 1'b1;
                        rd_addr  = cur_next;
                        cur_in   = cur_next;
                        state_in = ST_EVAL;
                     end
                  end else if (pos_w < {8'd0, lim}) begin
                     wr_en          = 1'b1;
                     wr_data        = unit_res.new_raw;
                     res_granted_in = pos_w[12:0];
                  end else begin
                     res_status_in = STAT_NOSPACE;
                  end
               end
               FN_FREE: begin
                  if (slot_oor) begin
                     res_status_in = STAT_RANGE;
                  end else if (!unit_res.bit_set) begin
                     res_status_in = STAT_NOTSET;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = unit_res.new_raw;
                  end
               end
               FN_WRITE: begin
                  if (addr_oor) begin
                     res_status_in = STAT_RANGE;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = win_ff;
                  end
               end
               default: begin
                  if (addr_oor) begin
                     res_status_in = STAT_RANGE;
                  end else begin
                     res_word_in = rd_data_ff;
                  end
               end
            endcase
         end

         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         swap_ff      <= 1'b0;
         c16_ff       <= 1'b0;
         total_ff     <= TOTAL_RESET;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SWAP:  swap_ff  <= csr_wdata[0];
               CSR_C16:   c16_ff   <= csr_wdata[0];
               CSR_TOTAL: total_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      slot_ff        <= slot_in;
      addr_ff        <= addr_in;
      win_ff         <= win_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_word_ff    <= res_word_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_word_ff    <= res_word_ff;
      end
   end

   // bitmap store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_word_out      = rsp_word_ff;

`ifndef SYNTHESIS
   a_reset_to_clear: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("sequencer not in clearing pass after reset");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_EVAL))
      else $error("store written outside clearing pass or evaluation");

   a_scan_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && state_in == ST_EVAL) |-> (func_ff == FN_ALLOC && unit_res.full))
      else $error("scan continued past a word with a clear bit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ISSUE && !req_ready))
      else $error("request transfer did not start the sequencer");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not moved to the response register");
`endif

endmodule

`default_nettype wire

// ===== tb/bitmap_slot_allocator_test.sv =====
// Self-checking testbench for bitmap_slot_allocator: allocate, free and raw word transfers
// under several register settings, each response checked against a bitmap image kept here.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL.
`timescale 1ns / 1ps

module bitmap_slot_allocator_test;
   import bsa_pkg::*;

   localparam int NUM_WORDS = 256;
   localparam int CAPACITY = NUM_WORDS * 32;
   localparam int HALF_PERIOD = 6;
   localparam int DRAIN_CYCLES = NUM_WORDS + 16;   // longest allocate scan plus margin
   localparam logic [1:0] CSR_SPARE = 2'd3;         // index with no register behind it

   typedef struct {
      logic [1:0]  status;
      logic [12:0] granted;
      logic [31:0] word;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FN_READ;
   logic [12:0] req_slot_index = '0;
   logic [7:0]  req_word_addr = '0;
   logic [31:0] req_word_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_granted_index;
   logic [31:0] rsp_word_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_SWAP;
   logic [13:0] csr_wdata = '0;

   // Local copy of the store and the registers
   logic [31:0] image [NUM_WORDS];
   logic        swap_reg;
   logic        c16_reg;
   logic [13:0] total_reg;
   reply_type   pending_replies[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int replies_seen = 0;
   int n_alloc = 0, n_nospace = 0, n_free = 0, n_free_rejected = 0;
   int n_write = 0, n_read = 0, n_config = 0;

   bitmap_slot_allocator #(.WORDS(NUM_WORDS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_slot_index    (req_slot_index),
      .req_word_addr     (req_word_addr),
      .req_word_in       (req_word_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_word_out      (rsp_word_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [12:0] rnd_slot();
      return 13'($urandom);
   endfunction

   function automatic logic [7:0] rnd_addr();
      return 8'($urandom);
   endfunction

   // Stored word <-> logical bit order; byte k trades places with byte k^1 or k^3
   function automatic logic [31:0] reorder(input logic [31:0] v);
      logic [31:0] r;
      r = v;
      if (swap_reg) begin
         for (int k = 0; k < 4; k++) begin
            r[8*k +: 8] = v[8*(k ^ (c16_reg ? 1 : 3)) +: 8];
         end
      end
      return r;
   endfunction

   function automatic int alloc_limit();
      return (int'(total_reg) < CAPACITY) ? int'(total_reg) : CAPACITY;
   endfunction

   // Applies one request to the image and gives the response it must produce
   function automatic reply_type apply_request(input logic [1:0] func, input logic [12:0] slot,
                                               input logic [7:0] addr, input logic [31:0] data);
      reply_type   r;
      logic [31:0] logical;
      int          lim;
      int          b;
      bit          done;
      r.status = STAT_OK;
      r.granted = '0;
      r.word = '0;
      lim = alloc_limit();
      case (func)
         FN_ALLOC: begin
            n_alloc++;
            r.status = STAT_NOSPACE;
            done = 1'b0;
            // lowest clear bit overall; if it lies at or past the bound there is no space
            for (int w = 0; w < NUM_WORDS && !done; w++) begin
               logical = reorder(image[w]);
               if (logical != '1) begin
                  b = 0;
                  while (logical[b]) b++;
                  if (w * 32 + b < lim) begin
                     logical[b] = 1'b1;
                     image[w] = reorder(logical);
                     r.granted = 13'(w * 32 + b);
                     r.status = STAT_OK;
                  end
                  done = 1'b1;
               end
            end
            if (r.status == STAT_NOSPACE) n_nospace++;
         end
         FN_FREE: begin
            n_free++;
            if (int'(slot) >= lim) begin
               r.status = STAT_RANGE;
            end else begin
               logical = reorder(image[slot[12:5]]);
               if (!logical[slot[4:0]]) begin
                  r.status = STAT_NOTSET;
               end else begin
                  logical[slot[4:0]] = 1'b0;
                  image[slot[12:5]] = reorder(logical);
               end
            end
            if (r.status != STAT_OK) n_free_rejected++;
         end
         FN_WRITE: begin
            n_write++;
            image[addr] = data;
         end
         default: begin
            n_read++;
            r.word = image[addr];
         end
      endcase
      return r;
   endfunction

   // Picks a slot that is currently set, in a word below the bound, if one turns up quickly
   function automatic logic [12:0] held_slot(input logic [12:0] fallback);
      logic [31:0] logical;
      int          lim;
      int          w;
      int          b;
      lim = alloc_limit();
      if (lim == 0) return fallback;
      for (int t = 0; t < 8; t++) begin
         w = $urandom_range(0, (lim - 1) >> 5);
         logical = reorder(image[w]);
         if (logical != '0) begin
            b = $urandom_range(31);
            while (!logical[b]) b = (b + 1) % 32;
            return 13'(w * 32 + b);
         end
      end
      return fallback;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= 40) begin
         $display("[%0t] response %0d: %s is %h, expected %h", $time, replies_seen, what,
                  got, want);
      end
   endtask

   // Response checker: oldest outstanding expectation first
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected response status", 32'(rsp_status), 32'd0);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_granted_index !== want.granted)
               report_mismatch("granted_index", 32'(rsp_granted_index), 32'(want.granted));
            if (rsp_word_out !== want.word)
               report_mismatch("word_out", rsp_word_out, want.word);
         end
      end
   end

   // One request transfer; valid stays up when the next request follows at once
   task automatic send_request(input logic [1:0] func, input logic [12:0] slot,
                               input logic [7:0] addr, input logic [31:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_slot_index <= slot;
      req_word_addr <= addr;
      req_word_in <= data;
      do @(posedge clock); while (!req_ready);
      pending_replies.push_back(apply_request(func, slot, addr, data));
   endtask

   // Holds off new requests until every response has been taken
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [13:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register (and the spare index) while the block is idle
   task automatic configure(input logic swap, input logic c16, input logic [13:0] total);
      wait_for_replies();
      write_register(CSR_SWAP, {13'($urandom), swap});
      write_register(CSR_SPARE, 14'($urandom));
      write_register(CSR_C16, {13'($urandom), c16});
      write_register(CSR_TOTAL, total);
      csr_valid <= 1'b0;
      swap_reg = swap;
      c16_reg = c16;
      total_reg = total;
      n_config++;
   endtask

   // Reset values: cleared store, plain byte order, full bound
   task automatic test_reset_state();
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_READ, rnd_slot(), 8'd0, $urandom);
      send_request(FN_FREE, 13'd0, rnd_addr(), $urandom);
      send_request(FN_FREE, 13'd0, rnd_addr(), $urandom);        // already clear
      send_request(FN_FREE, 13'd8191, rnd_addr(), $urandom);
      send_request(FN_WRITE, rnd_slot(), 8'd255, 32'hFFFF_FFFF);
      send_request(FN_READ, rnd_slot(), 8'd255, $urandom);
      send_request(FN_FREE, 13'd8191, rnd_addr(), $urandom);     // set by the raw write
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
   endtask

   // Zero bound, a bound inside a word, and a bound beyond capacity
   task automatic test_bounds();
      configure(1'b0, 1'b0, 14'd0);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_FREE, 13'd0, rnd_addr(), $urandom);
      send_request(FN_WRITE, rnd_slot(), 8'd3, $urandom);        // raw access ignores bound
      send_request(FN_READ, rnd_slot(), 8'd3, $urandom);
      configure(1'b1, 1'b1, 14'd40);
      send_request(FN_WRITE, rnd_slot(), 8'd0, 32'hFFFF_FFFF);
      send_request(FN_WRITE, rnd_slot(), 8'd1, 32'h0000_FF00);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);  // first clear bit sits on bound
      send_request(FN_FREE, 13'd40, rnd_addr(), $urandom);
      send_request(FN_FREE, 13'd39, rnd_addr(), $urandom);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      configure(1'b1, 1'b0, 14'd16383);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_READ, rnd_slot(), 8'd1, $urandom);
      send_request(FN_FREE, 13'd8191, rnd_addr(), $urandom);
   endtask

   // Mixed traffic: allocations, frees (often of held slots), raw writes and reads near the allocation frontier
   task automatic test_random_traffic(input int count);
      logic [1:0]  func;
      logic [12:0] slot;
      logic [7:0]  addr;
      logic [31:0] data;
      int          pick;
      int          lim;
      for (int i = 0; i < count; i++) begin
         lim = alloc_limit();
         pick = $urandom_range(99);
         func = (pick < 40) ? FN_ALLOC : (pick < 70) ? FN_FREE : (pick < 85) ? FN_WRITE : FN_READ;
         slot = rnd_slot();
         addr = rnd_addr();
         data = $urandom;
         if (func == FN_FREE) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               slot = held_slot(slot);
            end else if (pick < 80) begin
               slot = 13'($urandom_range(0, (lim + 40 > 8191) ? 8191 : lim + 40));
            end
         end else if (func != FN_ALLOC) begin
            if ($urandom_range(99) < 70)
               addr = 8'($urandom_range(0, ((lim >> 5) + 1 > 255) ? 255 : (lim >> 5) + 1));
            if (func == FN_WRITE) begin
               pick = $urandom_range(99);
               if (pick < 25) data = '1;
               else if (pick < 40) data = '0;
               else if (pick < 70) data = ~(32'd1 << $urandom_range(31));
            end
         end
         if ($urandom_range(99) == 0) wait_for_replies();
         send_request(func, slot, addr, data);
      end
   endtask

   // Every word full: no space at capacity, then the top slot freed and taken again
   task automatic test_capacity_edge();
      configure(1'b0, 1'b1, 14'd16383);
      for (int w = 0; w < NUM_WORDS; w++) begin
         send_request(FN_WRITE, rnd_slot(), 8'(w), 32'hFFFF_FFFF);
      end
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_FREE, 13'd8191, rnd_addr(), $urandom);
      send_request(FN_ALLOC, rnd_slot(), rnd_addr(), $urandom);
      send_request(FN_READ, rnd_slot(), 8'd255, $urandom);
   endtask

   initial begin
      int segment_bound [6];
      segment_bound = '{1, 16383, 100, 8192, 37, 0};
      foreach (image[w]) image[w] = '0;
      swap_reg = 1'b0;
      c16_reg = 1'b0;
      total_reg = TOTAL_RESET;
      send_idle_pct = 33;
      recv_idle_pct = 50;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_bounds();
      for (int s = 0; s < 6; s++) begin
         if (s == 2) begin
            send_idle_pct = 50;
            recv_idle_pct = 33;
         end
         if (s == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(1'(s % 2), 1'((s / 2) % 2),
                   (s == 5) ? 14'($urandom) : 14'(segment_bound[s]));
         test_random_traffic(210);
      end
      test_capacity_edge();

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d allocations (%0d found no space) and %0d frees (%0d refused),",
               n_alloc, n_nospace, n_free, n_free_rejected);
      $display("%0d raw writes and %0d raw reads over %0d register settings; %0d responses.",
               n_write, n_read, n_config, replies_seen);
      if (errors == 0 && pending_replies.size() == 0) begin
         $display("bitmap_slot_allocator: match");
      end else begin
         $display("bitmap_slot_allocator: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #50_000_000;
      $display("bitmap_slot_allocator: mismatch");
      $finish;
   end

endmodule
